[rtl/lkpc_pkg.sv]
// shared types, constants and codes of the lru keyed packet cache
package lkpc_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int MAX_BYTES_DEF = 512;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int CMD_DEPTH     = 2;
    localparam int RES_DEPTH     = 4;

    localparam logic [1:0] REQ_PUT    = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_PEEK   = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    localparam logic [1:0] MODE_LEN = 2'd1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MISS      = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_BUF_SMALL = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key;
        logic [9:0]  pkt_len;
        logic [63:0] data_word;
        logic        last;
        logic [1:0]  copy_mode;
        logic [9:0]  buf_capacity;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  out_len;
        logic [63:0] read_word;
        logic        last_result;
        logic [6:0]  entry_count;
    } t_out;

    typedef enum logic [2:0] {
        OP_PUT_WORD,
        OP_PUT_END,
        OP_GET,
        OP_PEEK,
        OP_REMOVE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] key;
        logic [9:0]  len;
        logic [63:0] word;
        logic        too_large;
        logic        copy;
        logic        len_only;
        logic [9:0]  cap;
    } t_cmd;

endpackage

[rtl/lkpc_fifo.sv]
// small first-in first-out queue of one packed type
module lkpc_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output T     o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wp] <= i_data;
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

[rtl/lkpc_front.sv]
// front end: accepts requests, classifies them and queues commands
module lkpc_front #(
    parameter int MAX_BYTES = lkpc_pkg::MAX_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lkpc_pkg::t_in   i_item,
    output logic            o_full,
    input  logic            i_cmd_pop,
    output logic            o_cmd_valid,
    output lkpc_pkg::t_cmd  o_cmd
);
    lkpc_pkg::t_cmd cmd;
    logic           empty;

    always_comb begin
        cmd.key       = i_item.key;
        cmd.len       = i_item.pkt_len;
        cmd.word      = i_item.data_word;
        cmd.too_large = (i_item.pkt_len > 10'(MAX_BYTES));
        cmd.copy      = i_item.copy_mode[1];
        cmd.len_only  = (i_item.copy_mode == lkpc_pkg::MODE_LEN);
        cmd.cap       = i_item.buf_capacity;
        case (i_item.req_type)
            lkpc_pkg::REQ_PUT:  cmd.op = i_item.last ? lkpc_pkg::OP_PUT_END
                                                     : lkpc_pkg::OP_PUT_WORD;
            lkpc_pkg::REQ_GET:  cmd.op = lkpc_pkg::OP_GET;
            lkpc_pkg::REQ_PEEK: cmd.op = lkpc_pkg::OP_PEEK;
            default:            cmd.op = lkpc_pkg::OP_REMOVE;
        endcase
    end

    lkpc_fifo #(
        .T     (lkpc_pkg::t_cmd),
        .DEPTH (lkpc_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_empty (empty),
        .o_data  (o_cmd)
    );

    assign o_cmd_valid = !empty;
endmodule

[rtl/lkpc_engine.sv]
// back end: key scan, lru list upkeep, payload store and result generation
module lkpc_engine #(
    parameter int ENTRIES   = lkpc_pkg::ENTRIES_DEF,
    parameter int MAX_BYTES = lkpc_pkg::MAX_BYTES_DEF,
    parameter int KEY_WIDTH = lkpc_pkg::KEY_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  lkpc_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            o_res_push,
    output lkpc_pkg::t_out  o_res,
    input  logic            i_res_full
);
    localparam int IW    = $clog2(ENTRIES);
    localparam int LW    = $clog2(ENTRIES + 1);
    localparam int WORDS = (MAX_BYTES + 7) / 8;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WCW   = $clog2(WORDS + 1);
    localparam int PLD   = ENTRIES << WW;
    localparam logic [LW-1:0] NIL = LW'(ENTRIES);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_LEN, S_DECIDE, S_FREE_RD, S_FREE_WAIT, S_INSTALL,
        S_STORE_START, S_STORE_RD, S_STORE_WR, S_UNL_RD, S_UNL_WR, S_UNL_CLR,
        S_DROP, S_PUSH_A, S_PUSH_B, S_OUT, S_CRD, S_COUT, S_EMIT
    } t_state;

    t_state                r_state;
    lkpc_pkg::t_cmd        r_cmd;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [WCW-1:0]        r_pwc;
    logic [LW-1:0]         r_sidx;
    logic                  r_cv;
    logic [IW-1:0]         r_cidx;
    logic [IW-1:0]         r_slot;
    logic                  r_hit;
    logic [9:0]            r_len;
    logic [WCW-1:0]        r_nw;
    logic [WCW-1:0]        r_w;
    logic [LW-1:0]         r_head;
    logic [LW-1:0]         r_tail;
    logic [LW-1:0]         r_depth;
    logic [LW-1:0]         r_total;
    logic                  r_valid [ENTRIES];
    logic                  r_fvalid [ENTRIES];
    logic                  r_fv_rd;
    logic [IW-1:0]         r_fa;
    logic [1:0]            r_st;
    logic [9:0]            r_olen;

    // memories
    logic [KEY_WIDTH-1:0]  key_mem  [ENTRIES];
    logic [9:0]            len_mem  [ENTRIES];
    logic [LW-1:0]         prev_mem [ENTRIES];
    logic [LW-1:0]         next_mem [ENTRIES];
    logic [IW-1:0]         fs_mem   [ENTRIES];
    logic [63:0]           pb_mem   [WORDS];
    logic [63:0]           pl_mem   [PLD];

    logic [KEY_WIDTH-1:0]  key_rd;
    logic [9:0]            len_rd;
    logic [LW-1:0]         prev_rd;
    logic [LW-1:0]         next_rd;
    logic [IW-1:0]         fs_rd;
    logic [63:0]           pb_rd;
    logic [63:0]           pl_rd;

    logic                  key_we;
    logic                  len_we;
    logic                  prev_we;
    logic [IW-1:0]         prev_wa;
    logic [LW-1:0]         prev_wd;
    logic                  next_we;
    logic [IW-1:0]         next_wa;
    logic [LW-1:0]         next_wd;
    logic                  fs_we;
    logic [IW-1:0]         fs_ra;
    logic                  pb_we;
    logic                  pl_we;
    logic [63:0]           pl_wd;
    logic [IW+WW-1:0]      pl_a;

    logic                  is_put;
    logic                  match;
    logic                  last_w;
    logic [2:0]            rem;
    logic [63:0]           tail_mask;
    logic [WCW-1:0]        nw_cmd;
    logic [WCW-1:0]        nw_len;
    t_state                after_store;

    assign is_put  = (r_cmd.op == lkpc_pkg::OP_PUT_END);
    assign match   = r_cv && r_valid[r_cidx] && (key_rd == r_key);
    assign fs_ra   = IW'(r_depth - 1'b1);
    assign pl_a    = {r_slot, r_w[WW-1:0]};
    assign nw_cmd  = WCW'((11'(r_cmd.len) + 11'd7) >> 3);
    assign nw_len  = WCW'((11'(r_len) + 11'd7) >> 3);
    assign rem     = r_cmd.len[2:0];
    assign last_w  = (r_w + 1'b1 == r_nw);
    assign tail_mask = ~({64{1'b1}} << {rem, 3'b000});
    assign after_store = !r_hit ? S_PUSH_A :
                         (r_head == LW'(r_slot)) ? S_EMIT : S_UNL_RD;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // store word: unsent words read as zero, bytes past the length cleared
    always_comb begin
        pl_wd = (r_w < r_pwc) ? pb_rd : 64'd0;
        if (last_w && rem != 3'd0) begin
            pl_wd = pl_wd & tail_mask;
        end
    end

    always_comb begin
        key_we  = 1'b0;
        len_we  = 1'b0;
        prev_we = 1'b0;
        prev_wa = r_slot;
        prev_wd = NIL;
        next_we = 1'b0;
        next_wa = r_slot;
        next_wd = NIL;
        fs_we   = 1'b0;
        pb_we   = 1'b0;
        pl_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                pb_we = i_cmd_valid && r_pwc < WCW'(WORDS) &&
                        (i_cmd.op == lkpc_pkg::OP_PUT_WORD ||
                         i_cmd.op == lkpc_pkg::OP_PUT_END);
            end
            S_INSTALL:     key_we = 1'b1;
            S_STORE_START: len_we = 1'b1;
            S_STORE_WR:    pl_we  = 1'b1;
            S_UNL_WR: begin
                prev_we = (next_rd != NIL);
                prev_wa = IW'(next_rd);
                prev_wd = prev_rd;
                next_we = (prev_rd != NIL);
                next_wa = IW'(prev_rd);
                next_wd = next_rd;
            end
            S_UNL_CLR: begin
                prev_we = 1'b1;
                next_we = 1'b1;
            end
            S_PUSH_A: begin
                prev_we = 1'b1;
                next_we = 1'b1;
                next_wd = r_head;
            end
            S_PUSH_B: begin
                prev_we = (r_head != NIL);
                prev_wa = IW'(r_head);
                prev_wd = LW'(r_slot);
            end
            S_DROP: fs_we = !is_put && r_depth < LW'(ENTRIES);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[r_slot] <= r_key;
        key_rd <= key_mem[IW'(r_sidx)];
    end

    always_ff @(posedge i_clk) begin
        if (len_we) len_mem[r_slot] <= r_cmd.len;
        len_rd <= len_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        prev_rd <= prev_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) next_mem[next_wa] <= next_wd;
        next_rd <= next_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (fs_we) fs_mem[IW'(r_depth)] <= r_slot;
        fs_rd <= fs_mem[fs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pb_we) pb_mem[r_pwc[WW-1:0]] <= i_cmd.word;
        pb_rd <= pb_mem[r_w[WW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (pl_we) pl_mem[pl_a] <= pl_wd;
        pl_rd <= pl_mem[pl_a];
    end

    always_comb begin
        o_res_push = 1'b0;
        o_res.status      = r_st;
        o_res.out_len     = r_olen;
        o_res.read_word   = 64'd0;
        o_res.last_result = 1'b1;
        o_res.entry_count = 7'(r_total);
        case (r_state)
            S_EMIT: o_res_push = !i_res_full;
            S_COUT: begin
                o_res_push        = !i_res_full;
                o_res.status      = lkpc_pkg::ST_OK;
                o_res.out_len     = r_len;
                o_res.read_word   = pl_rd;
                o_res.last_result = last_w;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_fv_rd <= r_fvalid[fs_ra];
        r_fa    <= fs_ra;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pwc   <= '0;
            r_cv    <= 1'b0;
            r_hit   <= 1'b0;
            r_head  <= NIL;
            r_tail  <= NIL;
            r_depth <= LW'(ENTRIES);
            r_total <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i]  <= 1'b0;
                r_fvalid[i] <= 1'b0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd  <= i_cmd;
                        r_key  <= KEY_WIDTH'(i_cmd.key);
                        r_sidx <= '0;
                        r_cv   <= 1'b0;
                        r_hit  <= 1'b0;
                        case (i_cmd.op)
                            lkpc_pkg::OP_PUT_WORD: begin
                                if (r_pwc < WCW'(WORDS)) r_pwc <= r_pwc + 1'b1;
                            end
                            lkpc_pkg::OP_PUT_END: begin
                                if (i_cmd.too_large) begin
                                    r_pwc   <= '0;
                                    r_st    <= lkpc_pkg::ST_TOO_LARGE;
                                    r_olen  <= '0;
                                    r_state <= S_EMIT;
                                end else begin
                                    if (r_pwc < WCW'(WORDS)) r_pwc <= r_pwc + 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_pwc   <= '0;
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_cv   <= (r_sidx < LW'(ENTRIES));
                    r_cidx <= IW'(r_sidx);
                    if (r_sidx < LW'(ENTRIES)) r_sidx <= r_sidx + 1'b1;
                    if (match) begin
                        r_slot  <= r_cidx;
                        r_hit   <= 1'b1;
                        r_cv    <= 1'b0;
                        r_state <= is_put ? S_STORE_START : S_LEN;
                    end else if (r_cv && r_cidx == IW'(ENTRIES - 1)) begin
                        r_cv <= 1'b0;
                        if (is_put) begin
                            if (r_depth != '0) begin
                                r_state <= S_FREE_RD;
                            end else begin
                                r_slot  <= IW'(r_tail);
                                r_state <= S_UNL_RD;
                            end
                        end else begin
                            r_st    <= lkpc_pkg::ST_MISS;
                            r_olen  <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_FREE_RD: r_state <= S_FREE_WAIT;
                S_FREE_WAIT: begin
                    r_slot  <= r_fv_rd ? fs_rd : r_fa;
                    r_depth <= r_depth - 1'b1;
                    r_state <= S_INSTALL;
                end
                S_INSTALL: begin
                    r_valid[r_slot] <= 1'b1;
                    r_total <= r_total + 1'b1;
                    r_state <= S_STORE_START;
                end
                S_STORE_START: begin
                    r_nw   <= nw_cmd;
                    r_w    <= '0;
                    r_st   <= lkpc_pkg::ST_OK;
                    r_olen <= '0;
                    if (nw_cmd == '0) begin
                        r_pwc   <= '0;
                        r_state <= after_store;
                    end else begin
                        r_state <= S_STORE_RD;
                    end
                end
                S_STORE_RD: r_state <= S_STORE_WR;
                S_STORE_WR: begin
                    if (!last_w) begin
                        r_w     <= r_w + 1'b1;
                        r_state <= S_STORE_RD;
                    end else begin
                        r_pwc   <= '0;
                        r_state <= after_store;
                    end
                end
                S_LEN: r_state <= S_DECIDE;
                S_DECIDE: begin
                    r_len <= len_rd;
                    if (r_cmd.op == lkpc_pkg::OP_REMOVE) begin
                        r_state <= S_UNL_RD;
                    end else if (r_cmd.copy && r_cmd.cap < len_rd) begin
                        r_st    <= lkpc_pkg::ST_BUF_SMALL;
                        r_olen  <= len_rd;
                        r_state <= S_EMIT;
                    end else if (r_cmd.op == lkpc_pkg::OP_PEEK &&
                                 r_head == LW'(r_slot)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_UNL_RD;
                    end
                end
                S_UNL_RD: r_state <= S_UNL_WR;
                S_UNL_WR: begin
                    if (r_head == LW'(r_slot)) r_head <= next_rd;
                    if (r_tail == LW'(r_slot)) r_tail <= prev_rd;
                    r_state <= S_UNL_CLR;
                end
                S_UNL_CLR: begin
                    if (r_cmd.op == lkpc_pkg::OP_PEEK || (is_put && r_hit)) begin
                        r_state <= S_PUSH_A;
                    end else begin
                        r_state <= S_DROP;
                    end
                end
                S_DROP: begin
                    r_valid[r_slot] <= 1'b0;
                    r_total <= r_total - 1'b1;
                    if (!is_put && r_depth < LW'(ENTRIES)) begin
                        r_fvalid[IW'(r_depth)] <= 1'b1;
                        r_depth <= r_depth + 1'b1;
                    end
                    r_st   <= lkpc_pkg::ST_OK;
                    r_olen <= '0;
                    case (r_cmd.op)
                        lkpc_pkg::OP_PUT_END: r_state <= S_INSTALL;
                        lkpc_pkg::OP_REMOVE:  r_state <= S_EMIT;
                        default:              r_state <= S_OUT;
                    endcase
                end
                S_PUSH_A: r_state <= S_PUSH_B;
                S_PUSH_B: begin
                    r_head <= LW'(r_slot);
                    if (r_tail == NIL) r_tail <= LW'(r_slot);
                    r_st   <= lkpc_pkg::ST_OK;
                    r_olen <= '0;
                    r_state <= is_put ? S_EMIT : S_OUT;
                end
                S_OUT: begin
                    r_st <= lkpc_pkg::ST_OK;
                    r_w  <= '0;
                    r_nw <= nw_len;
                    if (r_cmd.copy) begin
                        r_olen  <= r_len;
                        r_state <= (nw_len == '0) ? S_EMIT : S_CRD;
                    end else begin
                        r_olen  <= r_cmd.len_only ? r_len : 10'd0;
                        r_state <= S_EMIT;
                    end
                end
                S_CRD: r_state <= S_COUT;
                S_COUT: begin
                    if (!i_res_full) begin
                        if (last_w) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_w     <= r_w + 1'b1;
                            r_state <= S_CRD;
                        end
                    end
                end
                S_EMIT: begin
                    if (!i_res_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((LW+1)'(r_total) + (LW+1)'(r_depth) == (LW+1)'(ENTRIES)))
        else $error("live entries and free slots do not add up");
    a_list_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_head == NIL) == (r_tail == NIL)))
        else $error("lru head and tail disagree on an empty list");
    a_pop_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE_WAIT) |-> (r_depth != '0))
        else $error("free slot taken from an empty stack");
    a_found_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && match) |=> r_valid[r_slot])
        else $error("scan hit on an invalid slot");
`endif
endmodule

[rtl/lru_keyed_packet_cache_top.sv]
// top level of the lru keyed packet cache
// Fully associative cache of up to ENTRIES packets, each named by a key and
// holding up to MAX_BYTES bytes, with true lru order kept as a doubly linked
// list over the slots. Requests enter through a queue-style port (push/full)
// and results leave through another (empty/pop). A put word without last
// gives no result. Any request that looks a key up (put commit, get, peek,
// remove) first scans the key memory one slot per cycle; list upkeep then
// does read-modify-write of the link memories, a put commit reads each
// stored payload word from the put buffer and then writes it, and a copying
// get or peek reads each result word from the payload memory port before
// giving it, holding while the result queue is full. A front queue of
// requests and a result queue let the input and output sides stall
// independently of the engine. No clearing pass is needed after reset.
module lru_keyed_packet_cache_top #(
    parameter int ENTRIES   = lkpc_pkg::ENTRIES_DEF,
    parameter int MAX_BYTES = lkpc_pkg::MAX_BYTES_DEF,
    parameter int KEY_WIDTH = lkpc_pkg::KEY_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // request side: a transaction is push high while full is low
    input  logic           push,
    input  lkpc_pkg::t_in  i_in,
    output logic           full,
    // result side: a transaction is pop high while empty is low
    output logic           empty,
    input  logic           pop,
    output lkpc_pkg::t_out o_out
);
    // classified commands from front to engine
    lkpc_pkg::t_cmd cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    // results from engine to the output queue
    lkpc_pkg::t_out res;
    logic           res_push;
    logic           res_full;

    lkpc_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // engine runs one command at a time: scan, list update, store or copy
    lkpc_engine #(
        .ENTRIES   (ENTRIES),
        .MAX_BYTES (MAX_BYTES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    // result queue decouples the engine from the consumer
    lkpc_fifo #(
        .T     (lkpc_pkg::t_out),
        .DEPTH (lkpc_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_out)
    );
endmodule
